// ===== rtl/clp_pkg.sv =====
package clp_pkg;

    localparam int NAME_OFFSET_W = 12;
    localparam int NAME_LENGTH_W = 7;
    localparam int CODE_W        = 8;
    localparam int ENTRY_COUNT_W = 4;

    localparam logic [7:0] CHAR_NUL        = 8'h00;
    localparam logic [7:0] CHAR_COLON      = 8'h3A;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_ONE        = 8'h31;

    localparam logic [7:0] VERSION_DEFAULT = 8'h01;
    localparam logic [7:0] SANDBOX_NONE    = 8'hFF;

    typedef enum logic [2:0] {
        MODE_SEG,
        MODE_NAME,
        MODE_COLON,
        MODE_SKIP,
        MODE_DONE
    } mode_t;

    typedef enum logic [1:0] {
        META_IDLE,
        META_COLON1,
        META_COLON2,
        META_CHAR
    } meta_t;

endpackage

// ===== rtl/connection_list_parser.sv =====
// Connection list parser: one region byte per request, one request per cycle when not stalled.
// A result is registered in two steps: the input register takes the byte,
// then the parse step writes the result register.
// The parser takes one byte per cycle unless out_stall holds the input register and
// back-pressures in_stall. Reset (rst_n low, asynchronous) empties both
// registers and returns the parser to segment start; it also re-arms at region end.
module connection_list_parser #(
    parameter int REGION_BYTES = 4096,
    parameter int MAX_ENTRIES  = 8,
    parameter int NAME_MAX     = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          region_byte,
    input  logic                                region_last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                entry_valid,
    output logic [clp_pkg::NAME_OFFSET_W-1:0]   name_offset,
    output logic [clp_pkg::NAME_LENGTH_W-1:0]   name_length,
    output logic [clp_pkg::CODE_W-1:0]          version_code,
    output logic [clp_pkg::CODE_W-1:0]          sandbox_code,
    output logic [clp_pkg::ENTRY_COUNT_W-1:0]   entry_count,
    output logic                                list_done
);
    import clp_pkg::*;

    localparam int OFF_W = $clog2(REGION_BYTES);
    localparam int LEN_W = $clog2(NAME_MAX + 2);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [OFF_W-1:0] LAST_OFFSET = OFF_W'(REGION_BYTES - 1);
    localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(NAME_MAX);
    localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MAX_ENTRIES);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // parser state
    mode_t            mode_reg, mode_next;
    logic [OFF_W-1:0] byte_offset_reg, byte_offset_next;
    logic [OFF_W-1:0] cand_start_reg, cand_start_next;
    logic [LEN_W-1:0] cand_length_reg, cand_length_next;
    logic             cand_underscore_reg, cand_underscore_next;
    logic [1:0]       cand_colons_reg, cand_colons_next;
    logic             name_open_reg, name_open_next;
    logic [7:0]       open_version_reg, open_version_next;
    logic [7:0]       open_sandbox_reg, open_sandbox_next;
    meta_t            meta_step_reg, meta_step_next;
    logic [7:0]       meta_char_reg, meta_char_next;
    logic [CNT_W-1:0] entries_reg, entries_next;

    // result register
    logic                     out_valid_reg;
    logic                     res_entry_reg, res_entry_next;
    logic [NAME_OFFSET_W-1:0] res_offset_reg, res_offset_next;
    logic [NAME_LENGTH_W-1:0] res_length_reg, res_length_next;
    logic [CODE_W-1:0]        res_version_reg, res_version_next;
    logic [CODE_W-1:0]        res_sandbox_reg, res_sandbox_next;
    logic [ENTRY_COUNT_W-1:0] res_count_reg, res_count_next;
    logic                     res_done_reg, res_done_next;
    logic                     emit;

    logic advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;

    always_comb
    begin
        logic [7:0]       b;
        logic             is_end;
        logic             finish;
        logic             capped;
        logic [CNT_W-1:0] cnt_inc;
        logic [1:0]       want;

        b       = s1_byte_reg;
        is_end  = s1_last_reg || (byte_offset_reg >= LAST_OFFSET);
        finish  = 1'b0;
        capped  = 1'b0;
        cnt_inc = entries_reg + 1'b1;
        want    = cand_underscore_reg ? 2'd0 : 2'd1;

        mode_next            = mode_reg;
        byte_offset_next     = byte_offset_reg + 1'b1;
        cand_start_next      = cand_start_reg;
        cand_length_next     = cand_length_reg;
        cand_underscore_next = cand_underscore_reg;
        cand_colons_next     = cand_colons_reg;
        name_open_next       = name_open_reg;
        open_version_next    = open_version_reg;
        open_sandbox_next    = open_sandbox_reg;
        meta_step_next       = meta_step_reg;
        meta_char_next       = meta_char_reg;
        entries_next         = entries_reg;

        emit             = 1'b0;
        res_entry_next   = 1'b0;
        res_offset_next  = '0;
        res_length_next  = '0;
        res_version_next = VERSION_DEFAULT;
        res_sandbox_next = SANDBOX_NONE;
        res_count_next   = ENTRY_COUNT_W'(entries_reg);
        res_done_next    = 1'b1;

        case (mode_reg)
            MODE_SEG:
            begin
                if (b == CHAR_NUL)
                begin
                    finish = 1'b1;
                end
                else if (b == CHAR_COLON)
                begin
                    mode_next      = MODE_COLON;
                    meta_step_next = META_COLON1;
                end
                else
                begin
                    if (name_open_reg)
                    begin
                        capped           = (cnt_inc >= CNT_MAX);
                        emit             = 1'b1;
                        res_entry_next   = 1'b1;
                        res_offset_next  = NAME_OFFSET_W'(cand_start_reg);
                        res_length_next  = NAME_LENGTH_W'(cand_length_reg);
                        res_version_next = open_version_reg;
                        res_sandbox_next = open_sandbox_reg;
                        res_count_next   = ENTRY_COUNT_W'(cnt_inc);
                        res_done_next    = capped || is_end;
                        entries_next      = cnt_inc;
                        name_open_next    = 1'b0;
                        open_version_next = VERSION_DEFAULT;
                        open_sandbox_next = SANDBOX_NONE;
                    end
                    if (capped)
                    begin
                        mode_next = MODE_DONE;
                    end
                    else
                    begin
                        cand_start_next      = byte_offset_reg;
                        cand_length_next     = LEN_W'(1);
                        cand_underscore_next = (b == CHAR_UNDERSCORE);
                        cand_colons_next     = 2'd0;
                        mode_next            = MODE_NAME;
                    end
                end
            end
            MODE_NAME:
            begin
                if (b == CHAR_NUL)
                begin
                    if (cand_length_reg != '0 && cand_length_reg <= LEN_MAX
                        && cand_colons_reg == want)
                    begin
                        name_open_next    = 1'b1;
                        open_version_next = VERSION_DEFAULT;
                        open_sandbox_next = SANDBOX_NONE;
                    end
                    mode_next = MODE_SEG;
                end
                else
                begin
                    if (cand_length_reg <= LEN_MAX)
                        cand_length_next = cand_length_reg + 1'b1;
                    if (b == CHAR_COLON && cand_colons_reg < 2'd2)
                        cand_colons_next = cand_colons_reg + 1'b1;
                end
            end
            MODE_COLON:
            begin
                case (meta_step_reg)
                    META_COLON1:
                    begin
                        if (b == CHAR_COLON)
                            meta_step_next = META_COLON2;
                        else if (b == CHAR_NUL)
                            mode_next = MODE_SEG;
                        else
                            mode_next = MODE_SKIP;
                    end
                    META_COLON2:
                    begin
                        if (b != CHAR_NUL)
                        begin
                            meta_char_next = b;
                            meta_step_next = META_CHAR;
                        end
                        else
                            mode_next = MODE_SEG;
                    end
                    default:
                    begin
                        if (b == CHAR_NUL)
                        begin
                            if (name_open_reg)
                            begin
                                if (open_version_reg == VERSION_DEFAULT)
                                    open_version_next = meta_char_reg - CHAR_ZERO;
                                else if (open_sandbox_reg == SANDBOX_NONE)
                                    open_sandbox_next = meta_char_reg - CHAR_ONE;
                            end
                            mode_next = MODE_SEG;
                        end
                        else
                            mode_next = MODE_SKIP;
                    end
                endcase
                if (mode_next != MODE_COLON)
                    meta_step_next = META_IDLE;
            end
            MODE_SKIP:
            begin
                if (b == CHAR_NUL)
                    mode_next = MODE_SEG;
            end
            default:
            begin
            end
        endcase

        if (!emit && mode_next != MODE_DONE && (finish || is_end))
        begin
            emit = 1'b1;
            if (name_open_next)
            begin
                res_entry_next   = 1'b1;
                res_offset_next  = NAME_OFFSET_W'(cand_start_next);
                res_length_next  = NAME_LENGTH_W'(cand_length_next);
                res_version_next = open_version_next;
                res_sandbox_next = open_sandbox_next;
                res_count_next   = ENTRY_COUNT_W'(cnt_inc);
                entries_next     = cnt_inc;
                name_open_next   = 1'b0;
            end
            res_done_next = 1'b1;
            mode_next     = MODE_DONE;
        end

        if (is_end)
        begin
            mode_next            = MODE_SEG;
            byte_offset_next     = '0;
            cand_start_next      = '0;
            cand_length_next     = '0;
            cand_underscore_next = 1'b0;
            cand_colons_next     = 2'd0;
            name_open_next       = 1'b0;
            open_version_next    = VERSION_DEFAULT;
            open_sandbox_next    = SANDBOX_NONE;
            meta_step_next       = META_IDLE;
            meta_char_next       = '0;
            entries_next         = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            mode_reg            <= MODE_SEG;
            byte_offset_reg     <= '0;
            cand_start_reg      <= '0;
            cand_length_reg     <= '0;
            cand_underscore_reg <= 1'b0;
            cand_colons_reg     <= 2'd0;
            name_open_reg       <= 1'b0;
            open_version_reg    <= VERSION_DEFAULT;
            open_sandbox_reg    <= SANDBOX_NONE;
            meta_step_reg       <= META_IDLE;
            meta_char_reg       <= '0;
            entries_reg         <= '0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg       <= emit;
                mode_reg            <= mode_next;
                byte_offset_reg     <= byte_offset_next;
                cand_start_reg      <= cand_start_next;
                cand_length_reg     <= cand_length_next;
                cand_underscore_reg <= cand_underscore_next;
                cand_colons_reg     <= cand_colons_next;
                name_open_reg       <= name_open_next;
                open_version_reg    <= open_version_next;
                open_sandbox_reg    <= open_sandbox_next;
                meta_step_reg       <= meta_step_next;
                meta_char_reg       <= meta_char_next;
                entries_reg         <= entries_next;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_byte_reg <= region_byte;
            s1_last_reg <= region_last;
        end
        if (advance && emit)
        begin
            res_entry_reg   <= res_entry_next;
            res_offset_reg  <= res_offset_next;
            res_length_reg  <= res_length_next;
            res_version_reg <= res_version_next;
            res_sandbox_reg <= res_sandbox_next;
            res_count_reg   <= res_count_next;
            res_done_reg    <= res_done_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign entry_valid  = res_entry_reg;
    assign name_offset  = res_offset_reg;
    assign name_length  = res_length_reg;
    assign version_code = res_version_reg;
    assign sandbox_code = res_sandbox_reg;
    assign entry_count  = res_count_reg;
    assign list_done    = res_done_reg;

endmodule
